### sv/yre_pkg.sv
package yre_pkg;

    localparam int PAYLOAD_BYTES = 128;
    localparam int FRAME_LEN     = PAYLOAD_BYTES + 5;
    localparam int POS_W         = $clog2(FRAME_LEN + 1);
    localparam int ADDR_W        = $clog2(PAYLOAD_BYTES);
    localparam int WORDS         = PAYLOAD_BYTES / 4;
    localparam int WIDX_W        = $clog2(WORDS);

    localparam logic [7:0] SOH_BYTE = 8'h01;
    localparam logic [7:0] EOT_BYTE = 8'h04;
    localparam logic [7:0] ACK_BYTE = 8'h06;
    localparam logic [7:0] NAK_BYTE = 8'h15;
    localparam logic [7:0] CEE_BYTE = 8'h43;
    localparam logic [31:0] DONE_MARK = 32'hAAAAAAAA;
    localparam logic [15:0] CRC_POLY  = 16'h1021;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [1:0] KIND_SEND  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_ERASE = 2'd2;
    localparam logic [1:0] KIND_RESET = 2'd3;

    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_SPAN  = 2'd1;
    localparam logic [1:0] REG_PAGES = 2'd2;

    typedef enum logic [1:0] {
        PS_START = 2'd0,
        PS_DATA  = 2'd1,
        PS_EOT2  = 2'd2,
        PS_END   = 2'd3
    } proto_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
        logic       frame_end;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic [31:0] flash_addr;
        logic [31:0] flash_word;
        logic        last;
    } out_item_t;

    // Result selector the controller hands to the datapath.
    typedef enum logic [2:0] {
        RS_ACK,
        RS_NAK,
        RS_CEE,
        RS_ERASE,
        RS_MARK,
        RS_RESET,
        RS_WORD
    } res_sel_t;

    typedef struct packed {
        logic                 take_byte;   // absorb s_ item byte into frame
        logic                 clear_frame; // restart frame gathering
        logic                 rd_word;     // issue store read of one word
        logic [WIDX_W-1:0]    rd_idx;
        logic                 load_out;    // put a result into output register
        res_sel_t             sel;
        logic                 out_last;
        logic                 set_count1;
        logic                 inc_count;
    } dp_cmd_t;

    typedef struct packed {
        logic             frame_ok;   // full length, crc and complement good
        logic             lead_soh;
        logic             lead_eot;
        logic             num_zero;
        logic             num_match;  // block_num equals low byte of count
        logic             out_busy;
    } dp_stat_t;

    function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### sv/yre_datapath.sv
module yre_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  yre_pkg::in_item_t   in_item,
    input  yre_pkg::dp_cmd_t    cmd,
    output yre_pkg::dp_stat_t   stat,
    input  logic [31:0]         image_base,
    input  logic [31:0]         image_span,
    input  logic [7:0]          erase_pages,
    output logic                m_valid,
    input  logic                m_ready,
    output yre_pkg::out_item_t  m_item
);
    import yre_pkg::*;

    logic [POS_W-1:0]  byte_pos_reg;
    logic [7:0]        lead_reg, num_reg, comp_reg;
    logic [15:0]       crc_reg, rx_crc_reg;
    logic [15:0]       count_reg;
    logic [31:0]       store [WORDS];
    logic [31:0]       rd_word_reg;
    logic [WIDX_W-1:0] rd_idx_reg;
    logic              m_valid_reg;
    out_item_t         m_item_reg;
    logic [15:0]       prior_cnt;
    logic [31:0]       blk_base;
    logic [ADDR_W-1:0] wr_addr;
    out_item_t         res;

    assign wr_addr = ADDR_W'(byte_pos_reg - POS_W'(3));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_pos_reg <= '0;
            lead_reg     <= '0;
            num_reg      <= '0;
            comp_reg     <= '0;
            crc_reg      <= '0;
            rx_crc_reg   <= '0;
            count_reg    <= '0;
        end else begin
            if (cmd.clear_frame) begin
                byte_pos_reg <= '0;
                crc_reg      <= '0;
            end else if (cmd.take_byte) begin
                if (byte_pos_reg == POS_W'(0)) lead_reg <= in_item.rx_byte;
                else if (byte_pos_reg == POS_W'(1)) num_reg <= in_item.rx_byte;
                else if (byte_pos_reg == POS_W'(2)) comp_reg <= in_item.rx_byte;
                else if (byte_pos_reg < POS_W'(3 + PAYLOAD_BYTES))
                    crc_reg <= crc_byte(crc_reg, in_item.rx_byte);
                else if (byte_pos_reg == POS_W'(3 + PAYLOAD_BYTES))
                    rx_crc_reg[15:8] <= in_item.rx_byte;
                else if (byte_pos_reg == POS_W'(4 + PAYLOAD_BYTES))
                    rx_crc_reg[7:0] <= in_item.rx_byte;
                if (byte_pos_reg < POS_W'(FRAME_LEN))
                    byte_pos_reg <= byte_pos_reg + POS_W'(1);
            end
            if (cmd.set_count1) count_reg <= 16'd1;
            else if (cmd.inc_count) count_reg <= count_reg + 16'd1;
        end
    end

    // Payload store: byte-lane writes into words, one registered word read.
    always_ff @(posedge aclk) begin
        if (cmd.take_byte && !cmd.clear_frame && byte_pos_reg >= POS_W'(3)
                && byte_pos_reg < POS_W'(3 + PAYLOAD_BYTES))
            store[wr_addr[ADDR_W-1:2]][{wr_addr[1:0], 3'b000} +: 8] <= in_item.rx_byte;
        if (cmd.rd_word) begin
            rd_word_reg <= store[cmd.rd_idx];
            rd_idx_reg  <= cmd.rd_idx;
        end
    end

    assign stat.frame_ok  = (byte_pos_reg == POS_W'(FRAME_LEN)) && (crc_reg == rx_crc_reg)
                            && (comp_reg == ~num_reg);
    assign stat.lead_soh  = (lead_reg == SOH_BYTE);
    assign stat.lead_eot  = (lead_reg == EOT_BYTE);
    assign stat.num_zero  = (num_reg == 8'd0);
    assign stat.num_match = (num_reg == count_reg[7:0]);
    assign stat.out_busy  = m_valid_reg && !m_ready;

    // Block offset wraps at 16 bits before scaling.
    assign prior_cnt = count_reg - 16'd1;
    assign blk_base  = image_base + 32'(prior_cnt) * 32'(PAYLOAD_BYTES);

    always_comb begin
        res = '0;
        res.last = cmd.out_last;
        unique case (cmd.sel)
            RS_ACK:   res.tx_byte = ACK_BYTE;
            RS_NAK:   res.tx_byte = NAK_BYTE;
            RS_CEE:   res.tx_byte = CEE_BYTE;
            RS_ERASE: begin
                res.kind       = KIND_ERASE;
                res.flash_addr = image_base;
                res.flash_word = 32'(erase_pages);
            end
            RS_MARK: begin
                res.kind       = KIND_WRITE;
                res.flash_addr = image_base + image_span - 32'd4;
                res.flash_word = DONE_MARK;
            end
            RS_RESET: res.kind = KIND_RESET;
            RS_WORD: begin
                res.kind       = KIND_WRITE;
                res.flash_addr = blk_base + {rd_idx_reg, 2'b00};
                res.flash_word = rd_word_reg;
            end
            default: res = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.load_out) m_item_reg <= res;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

### sv/yre_controller.sv
module yre_controller (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  yre_pkg::in_item_t  in_item,
    input  yre_pkg::dp_stat_t  stat,
    output yre_pkg::dp_cmd_t   cmd
);
    import yre_pkg::*;

    typedef enum logic [2:0] {
        C_IDLE,
        C_DECODE,
        C_EMIT,
        C_WREAD,
        C_WEMIT
    } ctl_t;

    ctl_t              state_reg, state_next;
    proto_t            proto_reg, proto_next;
    res_sel_t          q_reg [3];
    res_sel_t          q_next [3];
    logic [1:0]        qn_reg, qn_next, qi_reg, qi_next;
    logic [WIDX_W-1:0] widx_reg, widx_next;
    logic              accept;

    assign s_ready = (state_reg == C_IDLE) && !stat.out_busy;
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        proto_next = proto_reg;
        q_next     = q_reg;
        qn_next    = qn_reg;
        qi_next    = qi_reg;
        widx_next  = widx_reg;
        cmd        = '0;
        cmd.sel    = RS_ACK;
        unique case (state_reg)
            C_IDLE: begin
                if (accept) begin
                    if (in_item.cmd == CMD_TICK) begin
                        if (proto_reg == PS_START) begin
                            cmd.load_out = 1'b1;
                            cmd.sel      = RS_CEE;
                            cmd.out_last = 1'b1;
                        end
                    end else begin
                        cmd.take_byte = 1'b1;
                        if (in_item.frame_end) state_next = C_DECODE;
                    end
                end
            end
            C_DECODE: begin
                // Frame complete: choose the response and, except for a data block, restart gathering.
                cmd.clear_frame = 1'b1;
                qi_next    = 2'd0;
                qn_next    = 2'd0;
                state_next = C_IDLE;
                if (stat.lead_soh && stat.frame_ok) begin
                    if (proto_reg == PS_START && stat.num_zero) begin
                        proto_next = PS_DATA;
                        cmd.set_count1 = 1'b1;
                        q_next = '{RS_ACK, RS_CEE, RS_ERASE};
                        qn_next = 2'd3;
                        state_next = C_EMIT;
                    end else if (proto_reg == PS_END && stat.num_zero) begin
                        proto_next = PS_START;
                        q_next = '{RS_MARK, RS_ACK, RS_RESET};
                        qn_next = 2'd3;
                        state_next = C_EMIT;
                    end else if (proto_reg == PS_DATA && stat.num_match) begin
                        widx_next  = '0;
                        state_next = C_WREAD;
                    end
                    if (state_next != C_WREAD) cmd.clear_frame = 1'b1;
                end else if (stat.lead_eot) begin
                    if (proto_reg == PS_DATA) begin
                        proto_next = PS_EOT2;
                        q_next = '{RS_NAK, RS_NAK, RS_NAK};
                        qn_next = 2'd1;
                        state_next = C_EMIT;
                    end else if (proto_reg == PS_EOT2) begin
                        proto_next = PS_END;
                        q_next = '{RS_ACK, RS_CEE, RS_CEE};
                        qn_next = 2'd2;
                        state_next = C_EMIT;
                    end
                end
                // Hold the payload for the word burst; clear afterwards.
                if (state_next == C_WREAD) cmd.clear_frame = 1'b0;
            end
            C_EMIT: begin
                if (!stat.out_busy) begin
                    cmd.load_out = 1'b1;
                    cmd.sel      = q_reg[qi_reg];
                    cmd.out_last = (qi_reg + 2'd1 == qn_reg);
                    qi_next      = qi_reg + 2'd1;
                    if (qi_reg + 2'd1 == qn_reg) state_next = C_IDLE;
                end
            end
            C_WREAD: begin
                cmd.rd_word = 1'b1;
                cmd.rd_idx  = widx_reg;
                state_next  = C_WEMIT;
            end
            C_WEMIT: begin
                if (!stat.out_busy) begin
                    cmd.load_out = 1'b1;
                    cmd.sel      = RS_WORD;
                    widx_next    = widx_reg + WIDX_W'(1);
                    if (widx_reg == WIDX_W'(WORDS - 1)) begin
                        // Burst done: queue the ACK, advance the count.
                        cmd.inc_count   = 1'b1;
                        cmd.clear_frame = 1'b1;
                        q_next  = '{RS_ACK, RS_ACK, RS_ACK};
                        qn_next = 2'd1;
                        qi_next = 2'd0;
                        state_next = C_EMIT;
                    end else begin
                        state_next = C_WREAD;
                    end
                end
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            proto_reg <= PS_START;
            qn_reg    <= '0;
            qi_reg    <= '0;
            widx_reg  <= '0;
            q_reg     <= '{RS_ACK, RS_ACK, RS_ACK};
        end else begin
            state_reg <= state_next;
            proto_reg <= proto_next;
            qn_reg    <= qn_next;
            qi_reg    <= qi_next;
            widx_reg  <= widx_next;
            q_reg     <= q_next;
        end
    end

endmodule

### sv/ymodem_receive_engine_unit.sv
// A byte without frame end gives no result; a tick gets a C only in start state. A
// frame end passes a decode state, then results go one per cycle while the sink is
// ready; a data block emits 32 word writes, each a store read then an output load.
// One byte per cycle while gathering unless the output stalls; next item after the
// burst drains. Reset (aresetn low, synchronous): protocol in start state, registers
// at defaults, output empty. The payload store has no reset; full frames rewrite it.
module ymodem_receive_engine_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  yre_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output yre_pkg::out_item_t  m_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import yre_pkg::*;

    logic [31:0] base_reg, span_reg;
    logic [7:0]  pages_reg;
    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic [1:0]  reg_idx;

    // Register file: one word per register at byte offset 4*i.
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= '0;
            span_reg  <= 32'd4;
            pages_reg <= 8'd40;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_BASE:  base_reg  <= pwdata;
                REG_SPAN:  span_reg  <= pwdata;
                REG_PAGES: pages_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_BASE:  prdata = base_reg;
            REG_SPAN:  prdata = span_reg;
            REG_PAGES: prdata = {24'd0, pages_reg};
            default:   prdata = '0;
        endcase
    end

    // Controller sequences frames and result bursts; datapath holds frame and output.
    yre_controller u_ctl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .in_item (s_item),
        .stat    (stat),
        .cmd     (cmd)
    );

    yre_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_item     (s_item),
        .cmd         (cmd),
        .stat        (stat),
        .image_base  (base_reg),
        .image_span  (span_reg),
        .erase_pages (pages_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

endmodule

### tb/ymodem_receive_engine_unit_test.sv
module ymodem_receive_engine_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import yre_pkg::*;

    // Clock, reset and ports of the block
    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_item;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ymodem_receive_engine_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Stimulus bytes waiting for the driver, and responses the engine owes us
    in_item_t  byte_queue[$];
    out_item_t owed_results[$];
    int        mismatch_count;
    int        transfers_in;
    int        queued_total;

    // Predictor copy of the configuration and protocol state
    logic [31:0] cfg_base;
    logic [31:0] cfg_span;
    logic [7:0]  cfg_pages;
    proto_t      p_state;
    logic [15:0] p_count;
    logic [7:0]  p_pos;
    logic [7:0]  p_lead;
    logic [7:0]  p_num;
    logic [7:0]  p_comp;
    logic [15:0] p_crc;
    logic [15:0] p_rxcrc;
    logic [7:0]  p_payload[PAYLOAD_BYTES];

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Advance the CRC-16/XMODEM remainder by one byte
    function automatic logic [15:0] crc_advance(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) c = {c[14:0], 1'b0} ^ 16'h1021;
            else       c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

    task automatic owe(logic [1:0] kind, logic [7:0] tx, logic [31:0] addr,
                       logic [31:0] word);
        out_item_t r;
        r.kind       = kind;
        r.tx_byte    = tx;
        r.flash_addr = addr;
        r.flash_word = word;
        r.last       = 1'b0;
        owed_results.push_back(r);
    endtask

    // Decode a closed frame against the protocol state; push owed responses
    task automatic decode_frame(logic [7:0] len);
        logic [31:0] base;
        logic [31:0] w;
        logic [15:0] prior;
        if (p_lead == SOH_BYTE) begin
            if (len < FRAME_LEN || p_crc != p_rxcrc) return;
            if (p_comp != ~p_num) return;
            if (p_state == PS_START && p_num == 8'd0) begin
                p_state = PS_DATA;
                p_count = 16'd1;
                owe(KIND_SEND, ACK_BYTE, '0, '0);
                owe(KIND_SEND, CEE_BYTE, '0, '0);
                owe(KIND_ERASE, 8'd0, cfg_base, {24'd0, cfg_pages});
            end else if (p_state == PS_END && p_num == 8'd0) begin
                p_state = PS_START;
                owe(KIND_WRITE, 8'd0, cfg_base + cfg_span - 32'd4, DONE_MARK);
                owe(KIND_SEND, ACK_BYTE, '0, '0);
                owe(KIND_RESET, 8'd0, '0, '0);
            end else if (p_state == PS_DATA && p_num == p_count[7:0]) begin
                prior = p_count - 16'd1;
                base  = cfg_base + {16'd0, prior} * PAYLOAD_BYTES;
                for (int i = 0; i < WORDS; i++) begin
                    w = {p_payload[4*i+3], p_payload[4*i+2],
                         p_payload[4*i+1], p_payload[4*i]};
                    owe(KIND_WRITE, 8'd0, base + 32'(4 * i), w);
                end
                p_count = p_count + 16'd1;
                owe(KIND_SEND, ACK_BYTE, '0, '0);
            end
        end else if (p_lead == EOT_BYTE) begin
            if (p_state == PS_DATA) begin
                p_state = PS_EOT2;
                owe(KIND_SEND, NAK_BYTE, '0, '0);
            end else if (p_state == PS_EOT2) begin
                p_state = PS_END;
                owe(KIND_SEND, ACK_BYTE, '0, '0);
                owe(KIND_SEND, CEE_BYTE, '0, '0);
            end
        end
    endtask

    // Predict the responses of one accepted transfer
    task automatic predict_item(in_item_t it);
        int prior_size;
        prior_size = owed_results.size();
        if (it.cmd == CMD_TICK) begin
            if (p_state == PS_START) owe(KIND_SEND, CEE_BYTE, '0, '0);
        end else begin
            if (p_pos == 0) p_lead = it.rx_byte;
            else if (p_pos == 1) p_num = it.rx_byte;
            else if (p_pos == 2) p_comp = it.rx_byte;
            else if (p_pos < 3 + PAYLOAD_BYTES) begin
                p_payload[p_pos - 3] = it.rx_byte;
                p_crc = crc_advance(p_crc, it.rx_byte);
            end else if (p_pos == 3 + PAYLOAD_BYTES) p_rxcrc[15:8] = it.rx_byte;
            else if (p_pos == 4 + PAYLOAD_BYTES) p_rxcrc[7:0] = it.rx_byte;
            if (p_pos < FRAME_LEN) p_pos = p_pos + 8'd1;
            if (it.frame_end) begin
                decode_frame(p_pos);
                p_pos = 8'd0;
                p_crc = 16'd0;
            end
        end
        // flag the final response of this transfer
        if (owed_results.size() > prior_size)
            owed_results[owed_results.size() - 1].last = 1'b1;
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // Driver: burst/gap pacing, hold valid and payload until the transfer
    int gap_left;
    int burst_left;
    bit in_taken;
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !in_taken) begin
            // hold the offered transfer
        end else if (gap_left > 0) begin
            s_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (byte_queue.size() > 0) begin
            s_valid <= 1'b1;
            s_item  <= byte_queue.pop_front();
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 40);
                gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Accepted input transfers feed the predictor
    always @(posedge aclk) begin
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            predict_item(s_item);
            transfers_in++;
        end
    end

    // Receiver stall pattern: phases of always-ready, random, and mostly-stalled,
    // broken by one long hold-off
    int stall_phase;
    int phase_left;
    int rx_cycle;
    always @(negedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle >= 100 && rx_cycle < 900) begin
            // hold off so the block fills up and stalls its input
            m_ready <= 1'b0;
        end else begin
            if (phase_left == 0) begin
                stall_phase <= $urandom_range(0, 2);
                phase_left  <= $urandom_range(20, 300);
            end else begin
                phase_left <= phase_left - 1;
            end
            case (stall_phase)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 1) == 1);
                default: m_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // Monitor: compare each response with the oldest owed one
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (owed_results.size() == 0) begin
                report_mismatch("unexpected result kind", 32'(m_item.kind), 32'd0);
            end else begin
                want = owed_results.pop_front();
                if (m_item.kind != want.kind)
                    report_mismatch("kind", 32'(m_item.kind), 32'(want.kind));
                if (m_item.tx_byte != want.tx_byte)
                    report_mismatch("tx_byte", 32'(m_item.tx_byte), 32'(want.tx_byte));
                if (m_item.flash_addr != want.flash_addr)
                    report_mismatch("flash_addr", m_item.flash_addr, want.flash_addr);
                if (m_item.flash_word != want.flash_word)
                    report_mismatch("flash_word", m_item.flash_word, want.flash_word);
                if (m_item.last != want.last)
                    report_mismatch("last", 32'(m_item.last), 32'(want.last));
            end
        end
    end

    // Stimulus helpers: queue bytes for the driver
    task automatic push_byte(logic [7:0] b, logic fend);
        in_item_t it;
        it.cmd       = CMD_BYTE;
        it.rx_byte   = b;
        it.frame_end = fend;
        byte_queue.push_back(it);
        queued_total++;
    endtask

    task automatic push_tick();
        in_item_t it;
        it.cmd       = CMD_TICK;
        it.rx_byte   = 8'($urandom);
        it.frame_end = 1'($urandom);
        byte_queue.push_back(it);
        queued_total++;
    endtask

    // Queue an SOH frame; corrupt selects a flaw (0 none, 1 crc, 2 comp,
    // 3 short frame that ends on the fifth payload byte)
    task automatic push_block(logic [7:0] num, int corrupt, int fill);
        logic [7:0]  data[PAYLOAD_BYTES];
        logic [15:0] crc;
        crc = 16'd0;
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            case (fill)
                0: data[i] = 8'h00;
                1: data[i] = 8'hFF;
                default: data[i] = 8'($urandom);
            endcase
            crc = crc_advance(crc, data[i]);
        end
        if (corrupt == 1) crc = crc ^ 16'(1 << $urandom_range(0, 15));
        push_byte(SOH_BYTE, 1'b0);
        push_byte(num, 1'b0);
        push_byte((corrupt == 2) ? num : ~num, 1'b0);
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            if (corrupt == 3 && i == 4) begin
                push_byte(data[i], 1'b1);
                return;
            end
            push_byte(data[i], 1'b0);
        end
        push_byte(crc[15:8], 1'b0);
        push_byte(crc[7:0], 1'b1);
    endtask

    task automatic push_eot();
        push_byte(EOT_BYTE, 1'b1);
    endtask

    task automatic push_noise(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0) push_tick();
            else push_byte(8'($urandom), ($urandom_range(0, 5) == 0));
        end
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            REG_BASE:  cfg_base  = value;
            REG_SPAN:  cfg_span  = value;
            default:   cfg_pages = value[7:0];
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Wait until every queued transfer is accepted and every response arrived
    task automatic drain();
        wait (byte_queue.size() == 0 && transfers_in == queued_total);
        wait (owed_results.size() == 0);
        repeat (80) @(posedge aclk);
    endtask

    task automatic configure(logic [31:0] base, logic [31:0] span, logic [7:0] pages);
        apb_write(REG_BASE, base);
        apb_write(REG_SPAN, span);
        apb_write(REG_PAGES, 32'(pages));
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item  = '0;
        m_ready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        mismatch_count = 0; transfers_in = 0; queued_total = 0;
        gap_left = 0; burst_left = 0; stall_phase = 0; phase_left = 0; rx_cycle = 0;
        cfg_base = 32'd0; cfg_span = 32'd4; cfg_pages = 8'd40;
        p_state = PS_START; p_count = '0; p_pos = '0; p_lead = '0; p_num = '0;
        p_comp = '0; p_crc = '0; p_rxcrc = '0;
        foreach (p_payload[i]) p_payload[i] = 8'h00;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed at defaults: tick, stray EOT, stray byte, short start block,
        // good start block during the long receiver hold-off, tick in data state
        push_tick();
        push_eot();
        push_byte(8'hFF, 1'b1);
        push_block(8'd0, 3, 0);
        push_block(8'd0, 0, 2);
        push_tick();
        drain();

        // Extreme configuration: data block addresses wrap past the top
        configure(32'hFFFF_FFC0, 32'hFFFF_FFFF, 8'd255);
        push_block(8'd1, 0, 2);
        push_eot();
        push_eot();
        push_eot();
        push_tick();
        push_noise(4);
        drain();

        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
